FILE: src/note_voice_allocator_unit_assert.svh
// assertion macros for the note voice allocator
// depends on nothing; taken in by note_voice_allocator_unit.sv, the rtl file that asserts
`ifndef NOTE_VOICE_ALLOCATOR_UNIT_ASSERT_SVH
`define NOTE_VOICE_ALLOCATOR_UNIT_ASSERT_SVH

// clocked check, switched off while reset is held
`define NVA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define NVA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/nva_pkg.sv
// shared types and constants of the note voice allocator
// no dependencies
`default_nettype none

package nva_pkg;

    // default number of voices
    localparam int VOICES_DEFAULT = 4;

    // gap clamping
    localparam logic [15:0] GAP_LIMIT   = 16'h00FF;
    localparam logic [15:0] GAP_CLAMPED = 16'h001F;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTEOFF_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VELOCITY   = 2'd2;

    // configuration reset values
    localparam logic [2:0] VOICE_COUNT_RST    = 3'd2;
    localparam logic       NOTEOFF_ENABLE_RST = 1'b1;
    localparam logic [6:0] MIN_VELOCITY_RST   = 7'd1;

    // incoming note event
    typedef struct packed {
        logic [15:0] delay_ticks;
        logic [7:0]  note_number;
        logic [3:0]  source_channel;
        logic [6:0]  velocity;
    } t_nva_in;

    // voice start or release record
    typedef struct packed {
        logic [8:0] delay_code;
        logic [7:0] out_note;
        logic [1:0] voice_index;
    } t_nva_out;

endpackage

`default_nettype wire

FILE: src/note_voice_allocator_unit.sv
// Note voice allocator: takes one note event per clock and gives at most one voice
// start or release record for it. An event is registered on entry, matched against
// all voices and assigned by compare and priority logic, and the record lands in an
// output register behind the input register; a new event is taken every cycle while
// the output side keeps up. Events that give no record leave nothing in the output
// register and never stall the input.
// Depends on nva_pkg and note_voice_allocator_unit_assert.svh.
`default_nettype none

`include "note_voice_allocator_unit_assert.svh"

module note_voice_allocator_unit #(
    parameter int VOICES = nva_pkg::VOICES_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [nva_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [nva_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // event requests
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire nva_pkg::t_nva_in               i_in_req,
    // voice records
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output nva_pkg::t_nva_out                   o_out_req
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int PW = 2 * CW;

    // configuration registers
    logic [2:0] r_voice_count;
    logic       r_noteoff_en;
    logic [6:0] r_min_vel;

    // voice state
    logic [7:0]    r_voice_note [VOICES];
    logic [3:0]    r_voice_src  [VOICES];
    logic [VW-1:0] r_rr_ptr;

    // input and output stages
    logic              r_in_valid;
    nva_pkg::t_nva_in  r_in;
    logic              r_out_valid;
    nva_pkg::t_nva_out r_out;

    // stage logic
    logic              hit_found;
    logic [VW-1:0]     hit_idx;
    logic              free_found;
    logic [VW-1:0]     free_idx;
    logic [VW-1:0]     pick;
    logic              do_release;
    logic              do_start;
    logic              has_result;
    logic              s1_advance;
    logic              s1_fire;
    logic [CW-1:0]     eff_count;
    logic [CW-1:0]     ptr_raw;
    logic [CW-1:0]     ptr_rem;
    logic [PW-1:0]     prod;
    logic [15:0]       gap;
    logic [VW-1:0]     n_rr_ptr;
    nva_pkg::t_nva_out n_out;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_count <= nva_pkg::VOICE_COUNT_RST;
            r_noteoff_en  <= nva_pkg::NOTEOFF_ENABLE_RST;
            r_min_vel     <= nva_pkg::MIN_VELOCITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nva_pkg::REG_VOICE_COUNT:    r_voice_count <= i_cfg_wdata[2:0];
                nva_pkg::REG_NOTEOFF_ENABLE: r_noteoff_en  <= i_cfg_wdata[0];
                nva_pkg::REG_MIN_VELOCITY:   r_min_vel     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // match search: highest matching voice, lowest free voice
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int c = 0; c < VOICES; c++) begin
            if (r_in.note_number != 8'd0 && r_voice_note[c] == r_in.note_number
                    && r_voice_src[c] == r_in.source_channel) begin
                hit_found = 1'b1;
                hit_idx   = VW'(c);
            end
        end
        for (int c = VOICES - 1; c >= 0; c--) begin
            if (r_voice_note[c] == 8'd0) begin
                free_found = 1'b1;
                free_idx   = VW'(c);
            end
        end
    end

    // decision for the registered event
    always_comb begin
        do_release = r_noteoff_en && hit_found && (r_in.velocity < r_min_vel);
        do_start   = !hit_found && (r_in.velocity >= r_min_vel)
                     && (r_in.note_number != 8'd0);
        has_result = do_release || do_start;
        pick       = free_found ? free_idx : r_rr_ptr;
    end

    // round-robin pointer: (pick + 1) modulo the clamped voice count
    always_comb begin
        if (r_voice_count == 3'd0) begin
            eff_count = CW'(1);
        end else if (int'(r_voice_count) > VOICES) begin
            eff_count = CW'(VOICES);
        end else begin
            eff_count = CW'(r_voice_count);
        end
        ptr_raw = CW'(pick) + CW'(1);
        ptr_rem = ptr_raw;
        prod    = '0;
        for (int q = 1; q <= VOICES; q++) begin
            prod = PW'(q) * PW'(eff_count);
            if (prod <= PW'(ptr_raw)) begin
                ptr_rem = CW'(PW'(ptr_raw) - prod);
            end
        end
        n_rr_ptr = VW'(ptr_rem);
    end

    // result record
    always_comb begin
        gap = (r_in.delay_ticks > nva_pkg::GAP_LIMIT) ? nva_pkg::GAP_CLAMPED
                                                      : r_in.delay_ticks;
        n_out.delay_code  = 9'(gap) + 9'd1;
        n_out.out_note    = do_start ? r_in.note_number : 8'd0;
        n_out.voice_index = do_start ? 2'(pick) : 2'(hit_idx);
    end

    // handshake
    always_comb begin
        s1_advance = !r_out_valid || i_out_ready || !has_result;
        s1_fire    = r_in_valid && s1_advance;
        o_in_ready = !r_in_valid || s1_advance;
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_fire && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
        if (s1_fire && has_result) begin
            r_out <= n_out;
        end
    end

    // voice table and pointer update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < VOICES; c++) begin
                r_voice_note[c] <= 8'd0;
                r_voice_src[c]  <= 4'd0;
            end
            r_rr_ptr <= '0;
        end else if (s1_fire) begin
            if (do_release) begin
                r_voice_note[hit_idx] <= 8'd0;
            end else if (do_start) begin
                r_voice_note[pick] <= r_in.note_number;
                r_voice_src[pick]  <= r_in.source_channel;
                r_rr_ptr           <= n_rr_ptr;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // checks
    `NVA_ASSERT(a_ptr_in_range, i_clk, i_rst_n,
        (int'(r_rr_ptr) < VOICES), "pointer past last voice")
    `NVA_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        (!r_out_valid |-> o_in_ready), "input stalled with empty output")
    `NVA_ASSERT(a_release_clears, i_clk, i_rst_n,
        (s1_fire && do_release |=> r_voice_note[$past(hit_idx)] == 8'd0),
        "released voice still holds a note")
    `NVA_ASSERT(a_start_loads, i_clk, i_rst_n,
        (s1_fire && do_start |=> r_voice_note[$past(pick)] == $past(r_in.note_number)),
        "started voice lacks its note")
    `NVA_ASSERT(a_code_nonzero, i_clk, i_rst_n,
        (r_out_valid |-> r_out.delay_code != 9'd0), "delay code of zero")

endmodule

`default_nettype wire

FILE: tb/sv/note_voice_allocator_unit_tb.sv
// self-checking testbench for note_voice_allocator_unit: directed and random event requests,
// with a scoreboard class that predicts each voice record and checks it on arrival
// depends on nva_pkg and the note_voice_allocator_unit rtl
`default_nettype none

module note_voice_allocator_unit_tb;

    localparam int NUM_VOICES  = 4;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 4;

    // voice state mirror, expected record queue and mismatch checking
    class voice_scoreboard;
        logic [7:0]        voice_note [NUM_VOICES];
        logic [3:0]        voice_src [NUM_VOICES];
        logic [1:0]        rr_ptr;
        logic [2:0]        voice_count;
        logic              noteoff_en;
        logic [6:0]        min_vel;
        nva_pkg::t_nva_out records [$];
        int                errors;

        function new();
            for (int v = 0; v < NUM_VOICES; v++) begin
                voice_note[v] = '0;
                voice_src[v]  = '0;
            end
            rr_ptr      = '0;
            voice_count = nva_pkg::VOICE_COUNT_RST;
            noteoff_en  = nva_pkg::NOTEOFF_ENABLE_RST;
            min_vel     = nva_pkg::MIN_VELOCITY_RST;
            errors      = 0;
        endfunction

        function void write_reg(logic [nva_pkg::CFG_IDX_W-1:0] idx,
                                logic [nva_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                nva_pkg::REG_VOICE_COUNT:    voice_count = data[2:0];
                nva_pkg::REG_NOTEOFF_ENABLE: noteoff_en  = data[0];
                nva_pkg::REG_MIN_VELOCITY:   min_vel     = data[6:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return records.size();
        endfunction

        // predict the record, if any, of one accepted event request
        function void note_event(nva_pkg::t_nva_in ev);
            int                hit;
            int                pick;
            int                modulus;
            logic [8:0]        code;
            nva_pkg::t_nva_out rec;
            hit = -1;
            if (ev.delay_ticks > nva_pkg::GAP_LIMIT)
                code = 9'(nva_pkg::GAP_CLAMPED) + 9'd1;
            else
                code = 9'(ev.delay_ticks) + 9'd1;
            // highest matching voice wins
            if (ev.note_number != 8'd0) begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (voice_note[v] == ev.note_number && voice_src[v] == ev.source_channel)
                        hit = v;
                end
            end
            // release of a sounding voice
            if (noteoff_en && hit >= 0 && ev.velocity < min_vel) begin
                voice_note[hit] = 8'd0;
                rec.delay_code  = code;
                rec.out_note    = 8'd0;
                rec.voice_index = 2'(hit);
                records.push_back(rec);
            end else if (hit < 0 && ev.velocity >= min_vel && ev.note_number != 8'd0) begin
                // lowest free voice, else the round-robin one
                pick = rr_ptr;
                for (int v = NUM_VOICES - 1; v >= 0; v--) begin
                    if (voice_note[v] == 8'd0)
                        pick = v;
                end
                voice_note[pick] = ev.note_number;
                voice_src[pick]  = ev.source_channel;
                modulus = voice_count;
                if (modulus == 0)
                    modulus = 1;
                if (modulus > NUM_VOICES)
                    modulus = NUM_VOICES;
                rr_ptr = 2'((pick + 1) % modulus);
                rec.delay_code  = code;
                rec.out_note    = ev.note_number;
                rec.voice_index = 2'(pick);
                records.push_back(rec);
            end
        endfunction

        // compare one voice record with the oldest prediction
        function void check_record(nva_pkg::t_nva_out got);
            nva_pkg::t_nva_out want;
            if (records.size() == 0) begin
                errors++;
                $display("%0t: unexpected record: expected none, %s %0d note %0d voice %0d",
                         $time, "actual delay", got.delay_code, got.out_note,
                         got.voice_index);
            end else begin
                want = records.pop_front();
                if (got.delay_code !== want.delay_code || got.out_note !== want.out_note ||
                    got.voice_index !== want.voice_index) begin
                    errors++;
                    $display("%0t: record mismatch: expected delay %0d note %0d voice %0d,",
                             $time, want.delay_code, want.out_note, want.voice_index,
                             " actual delay %0d note %0d voice %0d",
                             got.delay_code, got.out_note, got.voice_index);
                end
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [nva_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [nva_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    nva_pkg::t_nva_in               i_in_req = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    nva_pkg::t_nva_out              o_out_req;

    voice_scoreboard sb = new();
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    int              cycle_count = 0;
    logic [7:0]      held_note [NUM_VOICES];
    logic [3:0]      held_src [NUM_VOICES];

    note_voice_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    always #4 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d records outstanding", $time, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // record side: check on acceptance, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_record(o_out_req);
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // present one event request and hold it until accepted
    task automatic send_event(nva_pkg::t_nva_in ev);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_event(ev);
    endtask

    task automatic send_fields(int gap, int note, int src, int vel);
        nva_pkg::t_nva_in ev;
        ev.delay_ticks    = 16'(gap);
        ev.note_number    = 8'(note);
        ev.source_channel = 4'(src);
        ev.velocity       = 7'(vel);
        send_event(ev);
    endtask

    task automatic write_reg(logic [nva_pkg::CFG_IDX_W-1:0] idx, int data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= nva_pkg::CFG_DATA_W'(data);
        @(posedge i_clk);
        sb.write_reg(idx, nva_pkg::CFG_DATA_W'(data));
    endtask

    // let the block drain, then rewrite all registers
    task automatic apply_settings(int count, int noteoff, int minv);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        write_reg(nva_pkg::REG_VOICE_COUNT, count);
        write_reg(nva_pkg::REG_NOTEOFF_ENABLE, noteoff);
        write_reg(nva_pkg::REG_MIN_VELOCITY, minv);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly note-on/note-off traffic over a few notes so voices fill and release
    function automatic nva_pkg::t_nva_in random_event();
        nva_pkg::t_nva_in ev;
        int               slot;
        case ($urandom_range(3))
            0: ev.delay_ticks = 16'($urandom_range(255));
            1: ev.delay_ticks = 16'($urandom_range(65535, 256));
            2: ev.delay_ticks = 16'($urandom);
            default: ev.delay_ticks = ($urandom_range(3) == 0) ? 16'd10 : 16'($urandom_range(20));
        endcase
        slot = $urandom_range(NUM_VOICES - 1);
        if ($urandom_range(15) == 0) begin
            // pure noise
            ev.note_number    = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
            ev.source_channel = 4'($urandom);
            ev.velocity       = 7'($urandom);
        end else if ($urandom_range(1) == 0 && sb.min_vel != 7'd0) begin
            // release, usually of a recently started note
            if ($urandom_range(9) < 7) begin
                ev.note_number    = held_note[slot];
                ev.source_channel = held_src[slot];
            end else begin
                ev.note_number    = 8'($urandom_range(6, 1));
                ev.source_channel = 4'($urandom_range(2));
            end
            ev.velocity = 7'($urandom_range(sb.min_vel - 1));
        end else begin
            // start
            if ($urandom_range(7) == 0) begin
                ev.note_number    = 8'($urandom_range(255, 1));
                ev.source_channel = 4'($urandom);
            end else begin
                ev.note_number    = 8'($urandom_range(6, 1));
                ev.source_channel = 4'($urandom_range(2));
            end
            ev.velocity     = 7'($urandom_range(127, sb.min_vel));
            held_note[slot] = ev.note_number;
            held_src[slot]  = ev.source_channel;
        end
        return ev;
    endfunction

    initial begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            held_note[v] = 8'd1;
            held_src[v]  = 4'd0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, fill all voices, clamp edges, round-robin steal
        send_fields(0, 60, 0, 100);
        send_fields(255, 60, 5, 127);
        send_fields(256, 255, 15, 1);
        send_fields(65535, 1, 0, 64);
        send_fields(10, 2, 3, 90);
        // matched note-on, release, unmatched release, note zero
        send_fields(3, 2, 3, 50);
        send_fields(7, 255, 15, 0);
        send_fields(1, 77, 1, 0);
        send_fields(2, 0, 0, 100);
        send_fields(4, 0, 0, 0);
        send_fields(16'hAAAA, 128, 8, 127);
        send_fields(16'h5555, 127, 7, 85);

        // directed: note-offs disabled, then re-enabled with top threshold
        apply_settings(4, 0, 1);
        send_fields(5, 2, 3, 0);
        send_fields(10, 9, 9, 127);
        send_fields(0, 60, 5, 0);
        apply_settings(7, 1, 127);
        send_fields(6, 60, 5, 126);
        send_fields(8, 9, 9, 0);
        send_fields(12, 44, 2, 127);
        send_fields(13, 45, 2, 127);
        send_fields(10, 46, 2, 127);

        // random phases over settings and idle patterns
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_settings(4, 1, 1);
                1: apply_settings(1, 1, 64);
                2: apply_settings(0, 0, 1);
                3: apply_settings(7, 1, 127);
                4: apply_settings(3, 1, 0);
                5: apply_settings(2, 1, 40);
                6: apply_settings(4, 0, 100);
                default: apply_settings(4, 1, 20);
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            repeat (PHASE_ITEMS) send_event(random_event());
        end

        // drain and finish
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT + 2) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0t: %0d predicted records never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/nva_pkg.sv
src/note_voice_allocator_unit.sv
tb/sv/note_voice_allocator_unit_tb.sv
